// ----- hdl/scsg_pkg.sv -----
// Package for the store cap step governor.
// Holds widths, register indexes, reset values, shared types and the divide-by-100 helper.
// No dependencies.
package scsg_pkg;

  // Field and register widths
  localparam int unsigned LevelW    = 2;
  localparam int unsigned MaxLevel  = 3;
  localparam int unsigned PopW      = 16;
  localparam int unsigned EvW       = 32;
  localparam int unsigned PctW      = 7;
  localparam int unsigned PctPackW  = 28;
  localparam int unsigned EnterW    = 48;
  localparam int unsigned QuietW    = 8;
  localparam int unsigned CapW      = 16;
  localparam int unsigned CfgDataW  = 48;
  localparam int unsigned CfgIdxW   = 3;

  // Default step count
  localparam int unsigned NumStepsDef = 4;

  // Cap arithmetic: limit * percent, then exact divide by 100 through a reciprocal
  localparam int unsigned ProdW      = CapW + PctW;
  localparam int unsigned QuotW      = 17;
  localparam int unsigned RecipW     = 24;
  localparam int unsigned RecipShift = 30;
  localparam logic [RecipW-1:0] Div100Recip = 24'd10737419;

  // Register reset values
  localparam logic [EnterW-1:0]   EnterThreshRst = 48'hFFFF_FFFF_FFFF;
  localparam logic [PctPackW-1:0] PctPackRst     = 28'd211366500;
  localparam logic [PctW-1:0]     ReleaseRst     = 7'd75;
  localparam logic [QuietW-1:0]   QuietLimitRst  = 8'd3;
  localparam logic [CapW-1:0]     FloorRst       = 16'd0;
  localparam logic [CapW-1:0]     NodeLimitRst   = 16'd256;

  // Configuration register indexes
  typedef enum logic [CfgIdxW-1:0] {
    REG_ENTER_THRESH = 3'd0,
    REG_SAT_PCT      = 3'd1,
    REG_BULK_PCT     = 3'd2,
    REG_RELEASE_PCT  = 3'd3,
    REG_QUIET_LIMIT  = 3'd4,
    REG_SAT_FLOOR    = 3'd5,
    REG_ENV_FLOOR    = 3'd6,
    REG_NODE_LIMIT   = 3'd7
  } cfg_idx_e;

  // Load enables of the cap pipeline stages
  typedef struct packed {
    logic s2;
    logic s3;
    logic s4;
  } cap_ld_t;

  // Per-transaction flags carried alongside the caps
  typedef struct packed {
    logic [LevelW-1:0] level;
    logic              reclaim;
    logic              retry;
  } flags_t;

  // Exact floor(x / 100) for any x below 2^23
  function automatic logic [QuotW-1:0] div100(input logic [ProdW-1:0] x);
    logic [ProdW+RecipW-1:0] p;
    p = {{RecipW{1'b0}}, x} * {{ProdW{1'b0}}, Div100Recip};
    return p[RecipShift +: QuotW];
  endfunction

endpackage

// ----- hdl/scsg_if.sv -----
// Valid/ready channel interfaces for the store cap step governor.
// Input channel carries one evaluation, output channel one result.
// Depends on scsg_pkg.
interface scsg_in_if import scsg_pkg::*;;
  logic              valid;
  logic              ready;
  logic [PopW-1:0]   population;
  logic              store_full;
  logic [EvW-1:0]    eviction_count;

  modport source (output valid, population, store_full, eviction_count, input ready);
  modport sink   (input valid, population, store_full, eviction_count, output ready);
endinterface

interface scsg_out_if import scsg_pkg::*;;
  logic              valid;
  logic              ready;
  logic [LevelW-1:0] level;
  logic [CapW-1:0]   satellite_cap;
  logic [CapW-1:0]   environment_cap;
  logic              reclaim;
  logic              retry;

  modport source (output valid, level, satellite_cap, environment_cap, reclaim, retry,
                  input ready);
  modport sink   (input valid, level, satellite_cap, environment_cap, reclaim, retry,
                  output ready);
endinterface

// ----- hdl/scsg_cap.sv -----
// Three-stage cap pipeline: limit * percent, divide by 100, floor then clamp.
// Stage loads come from the top level's handshake control.
// Depends on scsg_pkg.
module scsg_cap import scsg_pkg::*; (
  input  logic                clk_i,
  input  cap_ld_t             ld_i,
  input  logic [LevelW-1:0]   level_i,
  input  logic [PctPackW-1:0] pct_pack_i,
  input  logic [CapW-1:0]     floor_i,
  input  logic [CapW-1:0]     limit_i,
  output logic [CapW-1:0]     cap_o
);

  logic [PctW-1:0]  pct;
  logic [ProdW-1:0] prod_q;
  logic [QuotW-1:0] quot_q;
  logic [QuotW-1:0] raised;
  logic [QuotW-1:0] clamped;
  logic [CapW-1:0]  cap_q;

  // Percentage of the level in hand
  assign pct = pct_pack_i[level_i * PctW +: PctW];

  // Stage 2: scale the node limit
  always_ff @(posedge clk_i) begin
    if (ld_i.s2) begin
      prod_q <= {{PctW{1'b0}}, limit_i} * {{CapW{1'b0}}, pct};
    end
  end

  // Stage 3: divide by 100
  always_ff @(posedge clk_i) begin
    if (ld_i.s3) begin
      quot_q <= div100(prod_q);
    end
  end

  // Floor first, then the node limit wins
  always_comb begin
    raised  = (quot_q < {1'b0, floor_i}) ? {1'b0, floor_i} : quot_q;
    clamped = (raised > {1'b0, limit_i}) ? {1'b0, limit_i} : raised;
  end

  // Stage 4: result register
  always_ff @(posedge clk_i) begin
    if (ld_i.s4) begin
      cap_q <= clamped[CapW-1:0];
    end
  end

  assign cap_o = cap_q;

endmodule

// ----- hdl/store_cap_step_governor.sv -----
// Store cap step governor: step level control and node caps per evaluation.
// A transaction passes the input register and stages 1 to 4 before its result is offered.
// Throughput: one transaction per cycle while the output is not stalled; the
// level/quiet/eviction update sits in one stage. Stalls ripple back stage by stage, so
// bubbles are filled while a result waits. Reset (async, active low) clears level, quiet
// run and last eviction count and returns every configuration register to its default.
module store_cap_step_governor import scsg_pkg::*; #(
  parameter int unsigned NUM_STEPS = NumStepsDef
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  scsg_in_if.sink             in_if,
  scsg_out_if.source          out_if,
  input  logic                cfg_we_i,
  input  logic [CfgIdxW-1:0]  cfg_index_i,
  input  logic [CfgDataW-1:0] cfg_data_i
);

  localparam int unsigned TopInt = (NUM_STEPS - 1 > MaxLevel) ? MaxLevel : NUM_STEPS - 1;
  localparam logic [LevelW-1:0] TopLevel = LevelW'(TopInt);
  localparam int unsigned ErW = 24;

  // Configuration registers
  logic [EnterW-1:0]   enter_thresh_q;
  logic [PctPackW-1:0] sat_pct_q;
  logic [PctPackW-1:0] bulk_pct_q;
  logic [PctW-1:0]     release_q;
  logic [QuietW-1:0]   quiet_limit_q;
  logic [CapW-1:0]     sat_floor_q;
  logic [CapW-1:0]     env_floor_q;
  logic [CapW-1:0]     node_limit_q;

  // Governor state
  logic [LevelW-1:0] level_q, level_d;
  logic [QuietW-1:0] quiet_q, quiet_d;
  logic [EvW-1:0]    last_ev_q, last_ev_d;

  // Pipeline valids and loads
  logic v0_q, v1_q, v2_q, v3_q, v4_q;
  logic take0, take1, take2, take3, take4;
  cap_ld_t cap_ld;

  // Input stage payload
  logic [PopW-1:0] pop_q;
  logic            full_q;
  logic [EvW-1:0]  ev_q;

  // Evaluation logic
  logic              pressure;
  logic [LevelW-1:0] warranted;
  logic [CapW-1:0]   entry_cur;
  logic [ErW-1:0]    er_prod;
  logic [ErW-1:0]    pop_lim;
  logic [QuietW-1:0] quiet_inc;
  logic              reclaim;
  logic              retry;

  flags_t flags_s1_q, flags_s2_q, flags_s3_q, flags_s4_q;

  logic [CapW-1:0] sat_cap, bulk_cap;

  // Configuration writes
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      enter_thresh_q <= EnterThreshRst;
      sat_pct_q      <= PctPackRst;
      bulk_pct_q     <= PctPackRst;
      release_q      <= ReleaseRst;
      quiet_limit_q  <= QuietLimitRst;
      sat_floor_q    <= FloorRst;
      env_floor_q    <= FloorRst;
      node_limit_q   <= NodeLimitRst;
    end else if (cfg_we_i) begin
      case (cfg_idx_e'(cfg_index_i))
        REG_ENTER_THRESH: enter_thresh_q <= cfg_data_i[EnterW-1:0];
        REG_SAT_PCT:      sat_pct_q      <= cfg_data_i[PctPackW-1:0];
        REG_BULK_PCT:     bulk_pct_q     <= cfg_data_i[PctPackW-1:0];
        REG_RELEASE_PCT:  release_q      <= cfg_data_i[PctW-1:0];
        REG_QUIET_LIMIT:  quiet_limit_q  <= cfg_data_i[QuietW-1:0];
        REG_SAT_FLOOR:    sat_floor_q    <= cfg_data_i[CapW-1:0];
        REG_ENV_FLOOR:    env_floor_q    <= cfg_data_i[CapW-1:0];
        REG_NODE_LIMIT:   node_limit_q   <= cfg_data_i[CapW-1:0];
        default: ;
      endcase
    end
  end

  // Stage loads: a stage takes new data when empty or when its content moves on
  assign take4 = !v4_q || out_if.ready;
  assign take3 = !v3_q || take4;
  assign take2 = !v2_q || take3;
  assign take1 = !v1_q || take2;
  assign take0 = !v0_q || take1;

  assign in_if.ready = take0;
  assign cap_ld      = '{s2: take2, s3: take3, s4: take4};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v0_q <= 1'b0;
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
      v4_q <= 1'b0;
    end else begin
      if (take0) v0_q <= in_if.valid;
      if (take1) v1_q <= v0_q;
      if (take2) v2_q <= v1_q;
      if (take3) v3_q <= v2_q;
      if (take4) v4_q <= v3_q;
    end
  end

  // Input register
  always_ff @(posedge clk_i) begin
    if (take0) begin
      pop_q  <= in_if.population;
      full_q <= in_if.store_full;
      ev_q   <= in_if.eviction_count;
    end
  end

  // Highest step whose entry population is reached
  always_comb begin
    warranted = '0;
    for (int i = 1; i <= MaxLevel; i++) begin
      if (i <= TopInt && pop_q >= enter_thresh_q[(i - 1) * CapW +: CapW]) begin
        warranted = LevelW'(i);
      end
    end
  end

  // Entry threshold of the current step; step 0 has none
  always_comb begin
    case (level_q)
      2'd1:    entry_cur = enter_thresh_q[0 +: CapW];
      2'd2:    entry_cur = enter_thresh_q[CapW +: CapW];
      2'd3:    entry_cur = enter_thresh_q[2 * CapW +: CapW];
      default: entry_cur = '1;
    endcase
  end

  // pop >= floor(entry * release / 100)  <=>  entry * release < (pop + 1) * 100
  assign er_prod   = {{(ErW - CapW){1'b0}}, entry_cur} * {{(ErW - PctW){1'b0}}, release_q};
  assign pop_lim   = ({{(ErW - PopW){1'b0}}, pop_q} + ErW'(1)) * ErW'(100);
  assign quiet_inc = quiet_q + QuietW'(1);
  assign pressure  = full_q || (ev_q != last_ev_q);

  // Step decision
  always_comb begin
    level_d   = level_q;
    quiet_d   = quiet_q;
    last_ev_d = last_ev_q;
    reclaim   = 1'b0;
    retry     = 1'b0;
    if (pop_q == '0) begin
      retry = 1'b1;
    end else begin
      last_ev_d = ev_q;
      if (warranted > level_q) begin
        if (pressure) begin
          quiet_d = '0;
          level_d = (level_q >= TopLevel) ? TopLevel : level_q + LevelW'(1);
        end
      end else if (level_q != '0) begin
        if (er_prod < pop_lim) begin
          quiet_d = '0;
        end else begin
          quiet_d = quiet_inc;
          if (quiet_inc >= quiet_limit_q) begin
            quiet_d = '0;
            level_d = level_q - LevelW'(1);
            reclaim = 1'b1;
          end
        end
      end
    end
  end

  // State moves with the transaction leaving the input register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      level_q   <= '0;
      quiet_q   <= '0;
      last_ev_q <= '0;
    end else if (take1 && v0_q) begin
      level_q   <= level_d;
      quiet_q   <= quiet_d;
      last_ev_q <= last_ev_d;
    end
  end

  // Flag pipeline alongside the caps
  always_ff @(posedge clk_i) begin
    if (take1) flags_s1_q <= '{level: level_d, reclaim: reclaim, retry: retry};
    if (take2) flags_s2_q <= flags_s1_q;
    if (take3) flags_s3_q <= flags_s2_q;
    if (take4) flags_s4_q <= flags_s3_q;
  end

  // Cap units
  scsg_cap u_sat_cap (
    .clk_i      (clk_i),
    .ld_i       (cap_ld),
    .level_i    (flags_s1_q.level),
    .pct_pack_i (sat_pct_q),
    .floor_i    (sat_floor_q),
    .limit_i    (node_limit_q),
    .cap_o      (sat_cap)
  );

  scsg_cap u_bulk_cap (
    .clk_i      (clk_i),
    .ld_i       (cap_ld),
    .level_i    (flags_s1_q.level),
    .pct_pack_i (bulk_pct_q),
    .floor_i    (env_floor_q),
    .limit_i    (node_limit_q),
    .cap_o      (bulk_cap)
  );

  // Result channel
  assign out_if.valid           = v4_q;
  assign out_if.level           = flags_s4_q.level;
  assign out_if.satellite_cap   = sat_cap;
  assign out_if.environment_cap = bulk_cap;
  assign out_if.reclaim         = flags_s4_q.reclaim;
  assign out_if.retry           = flags_s4_q.retry;

endmodule
